>>> design/cqs_pkg.sv
// shared types, codes and constants for the circular queue with search
package cqs_pkg;

  localparam int DATA_W        = 32;
  localparam int CAP_W         = 7;
  localparam int SLOT_W        = 6;
  localparam int DEPTH_DEF     = 64;
  localparam int CAP_RESET_MAX = 64;

  // command codes
  localparam logic [1:0] CMD_ENQ    = 2'd0;
  localparam logic [1:0] CMD_DEQ    = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;
  localparam logic [1:0] CMD_STATUS = 2'd3;

  // status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]               cmd;
    logic signed [DATA_W-1:0] data_value;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] rear_value;
    logic [CAP_W-1:0]         entry_count;
    logic                     is_empty;
    logic                     is_full;
    logic                     match_found;
    logic [SLOT_W-1:0]        match_slot;
  } out_beat_t;

  // controls broadcast from the sequencer to every cell
  typedef struct packed {
    logic wr_en;
    logic tok_load;
    logic tok_shift;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_READ,
    S_PUSH
  } state_t;

endpackage

>>> design/cqs_cell.sv
// one queue slot: data word, search token and compare
module cqs_cell
  import cqs_pkg::*;
#(
  parameter int PTR_W = 6,
  parameter int INDEX = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cell_cmd_t                cmd,
  input  logic [PTR_W-1:0]         addr,
  input  logic [PTR_W-1:0]         cap_last,
  input  logic signed [DATA_W-1:0] wr_data,
  input  logic signed [DATA_W-1:0] key,
  input  logic                     tok_in,
  output logic                     tok_out,
  output logic                     wrap_out,
  output logic                     hit,
  output logic signed [DATA_W-1:0] rd_data
);

  logic                     sel;
  logic                     last;
  logic                     token;
  logic signed [DATA_W-1:0] data;

  // slot decode and wrap point
  assign sel  = (addr == PTR_W'(INDEX));
  assign last = (cap_last == PTR_W'(INDEX));

  // stored word
  always_ff @(posedge clk) begin
    if (cmd.wr_en && sel) begin
      data <= wr_data;
    end
  end

  // search token, loaded at the front slot and walked down the row
  always_ff @(posedge clk) begin
    if (rst) begin
      token <= 1'b0;
    end else if (cmd.tok_load) begin
      token <= sel;
    end else if (cmd.tok_shift) begin
      token <= tok_in;
    end
  end

  // hand the token on, or back to slot zero at the wrap point
  assign tok_out  = token && !last;
  assign wrap_out = token && last;
  assign hit      = token && (data == key);
  assign rd_data  = sel ? data : '0;

endmodule

>>> design/cqs_ctrl.sv
// sequencer: pointers, count, capacity register, search walk and result register
module cqs_ctrl
  import cqs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int PTR_W = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  in_beat_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_beat_t                out_data,
  input  logic                     cfg_we,
  input  logic [CAP_W-1:0]         cfg_data,
  output cell_cmd_t                cell_cmd,
  output logic [PTR_W-1:0]         addr,
  output logic [PTR_W-1:0]         cap_last,
  output logic signed [DATA_W-1:0] key,
  input  logic                     hit,
  input  logic signed [DATA_W-1:0] rd_data
);

  localparam int IW = ((PTR_W > CAP_W) ? PTR_W : CAP_W) + 1;
  localparam logic [CAP_W-1:0] CAP_RESET =
    CAP_W'((DEPTH < CAP_RESET_MAX) ? DEPTH : CAP_RESET_MAX);
  localparam logic [PTR_W-1:0] TAIL_RESET = PTR_W'(IW'(CAP_RESET) - IW'(1));

  state_t                   state;
  state_t                   state_next;
  logic [CAP_W-1:0]         cap;
  logic [CAP_W-1:0]         cfg_cap;
  logic [PTR_W-1:0]         head;
  logic [PTR_W-1:0]         tail;
  logic [PTR_W-1:0]         tail_adv;
  logic [PTR_W-1:0]         head_adv;
  logic [CAP_W-1:0]         count;
  logic [CAP_W-1:0]         remaining;
  logic [PTR_W-1:0]         walk;
  logic [1:0]               status_q;
  logic                     found_q;
  logic [PTR_W-1:0]         slot_q;
  logic signed [DATA_W-1:0] front_q;
  logic signed [DATA_W-1:0] rear_q;
  logic                     accept;
  logic                     q_empty;
  logic                     q_full;
  logic                     out_free;
  logic                     out_load;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p,
                                                input logic [CAP_W-1:0] c);
    logic [IW-1:0] s;
    s = IW'(p) + IW'(1);
    return (s >= IW'(c)) ? '0 : PTR_W'(s);
  endfunction

  assign accept   = in_valid && (state == S_IDLE);
  assign q_empty  = (count == '0);
  assign q_full   = (count >= cap);
  assign out_free = !out_valid || !out_stall;
  assign tail_adv = next_ptr(tail, cap);
  assign head_adv = next_ptr(head, cap);
  assign cap_last = PTR_W'(IW'(cap) - IW'(1));

  // written capacity, clamped to one..DEPTH
  always_comb begin
    if (cfg_data == '0) begin
      cfg_cap = CAP_W'(1);
    end else if (IW'(cfg_data) > IW'(DEPTH)) begin
      cfg_cap = CAP_W'(DEPTH);
    end else begin
      cfg_cap = cfg_data;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (in_data.cmd)
            CMD_DEQ:    state_next = (count > CAP_W'(1)) ? S_READ : S_PUSH;
            CMD_SEARCH: state_next = q_empty ? S_PUSH : S_SEARCH;
            default:    state_next = S_PUSH;
          endcase
        end
      end
      S_SEARCH: begin
        if (hit || remaining == CAP_W'(1)) begin
          state_next = S_PUSH;
        end
      end
      S_READ: state_next = S_PUSH;
      S_PUSH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_stall           = (state != S_IDLE);
    cell_cmd.wr_en     = accept && (in_data.cmd == CMD_ENQ) && !q_full;
    cell_cmd.tok_load  = accept && (in_data.cmd == CMD_SEARCH);
    cell_cmd.tok_shift = (state == S_SEARCH);
    out_load           = (state == S_PUSH) && out_free;
    if (state == S_IDLE && in_data.cmd == CMD_ENQ) begin
      addr = tail_adv;
    end else begin
      addr = head;
    end
  end

  // queue state, walk and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cap       <= CAP_RESET;
      head      <= '0;
      tail      <= TAIL_RESET;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        cap   <= cfg_cap;
        head  <= '0;
        tail  <= PTR_W'(IW'(cfg_cap) - IW'(1));
        count <= '0;
      end else if (accept) begin
        status_q <= STAT_OK;
        found_q  <= 1'b0;
        slot_q   <= '0;
        case (in_data.cmd)
          CMD_ENQ: begin
            if (q_full) begin
              status_q <= STAT_FULL;
            end else begin
              tail   <= tail_adv;
              count  <= count + CAP_W'(1);
              rear_q <= in_data.data_value;
              if (q_empty) begin
                front_q <= in_data.data_value;
              end
            end
          end
          CMD_DEQ: begin
            if (q_empty) begin
              status_q <= STAT_EMPTY;
            end else begin
              head  <= head_adv;
              count <= count - CAP_W'(1);
            end
          end
          CMD_SEARCH: begin
            if (q_empty) begin
              status_q <= STAT_EMPTY;
            end
            key       <= in_data.data_value;
            remaining <= count;
            walk      <= head;
          end
          default: begin
          end
        endcase
      end

      // one slot per cycle along the row
      if (state == S_SEARCH) begin
        if (hit) begin
          found_q <= 1'b1;
          slot_q  <= walk;
        end else begin
          remaining <= remaining - CAP_W'(1);
          walk      <= next_ptr(walk, cap);
        end
      end

      // new front word after a dequeue
      if (state == S_READ) begin
        front_q <= rd_data;
      end

      // result register
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded from the queue state after the step
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.status      <= status_q;
      out_data.front_value <= q_empty ? '0 : front_q;
      out_data.rear_value  <= q_empty ? '0 : rear_q;
      out_data.entry_count <= count;
      out_data.is_empty    <= q_empty;
      out_data.is_full     <= (count == cap);
      out_data.match_found <= found_q;
      out_data.match_slot  <= SLOT_W'(slot_q);
    end
  end

endmodule

>>> design/circular_queue_with_search.sv
// circular queue of signed words with search, built as a row of slot cells
//
//   channel  | handshake             | beat
//   ---------+-----------------------+-----------------------------------------
//   in       | in_valid / in_stall   | in_data  (cmd, data_value)
//   out      | out_valid / out_stall | out_data (status, front/rear, count, ...)
//   cfg      | cfg_we                | cfg_data (capacity)
//
// enqueue, status and rejected commands go straight to the result push, a dequeue
// that leaves values behind first reads the new front slot (registered read), and a
// search walks the token one slot per cycle until a hit or the last stored entry.
// synchronous reset restores pointers, count and capacity; slot words are not cleared.
// a stalled result waits in the output register; the next item is still taken,
// and its own result waits in the sequencer until the output register frees.
module circular_queue_with_search
  import cqs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_beat_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_beat_t        out_data,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_data
);

  localparam int PTR_W = $clog2(DEPTH);

  cell_cmd_t                cell_cmd;
  logic [PTR_W-1:0]         addr;
  logic [PTR_W-1:0]         cap_last;
  logic signed [DATA_W-1:0] key;
  logic                     hit;
  logic signed [DATA_W-1:0] rd_data;
  logic [DEPTH-1:0]         tok_in;
  logic [DEPTH-1:0]         tok_out;
  logic [DEPTH-1:0]         wrap_out;
  logic [DEPTH-1:0]         hit_vec;
  logic signed [DATA_W-1:0] rd_vec [DEPTH];

  cqs_ctrl #(
    .DEPTH (DEPTH),
    .PTR_W (PTR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cell_cmd  (cell_cmd),
    .addr      (addr),
    .cap_last  (cap_last),
    .key       (key),
    .hit       (hit),
    .rd_data   (rd_data)
  );

  // token ring: each cell feeds the next, the wrap cell feeds slot zero
  always_comb begin
    tok_in    = '0;
    tok_in[0] = (|wrap_out) || tok_out[DEPTH-1];
    for (int i = 1; i < DEPTH; i++) begin
      tok_in[i] = tok_out[i-1];
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    cqs_cell #(
      .PTR_W (PTR_W),
      .INDEX (g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cell_cmd),
      .addr     (addr),
      .cap_last (cap_last),
      .wr_data  (in_data.data_value),
      .key      (key),
      .tok_in   (tok_in[g]),
      .tok_out  (tok_out[g]),
      .wrap_out (wrap_out[g]),
      .hit      (hit_vec[g]),
      .rd_data  (rd_vec[g])
    );
  end

  // match flag and selected slot word
  assign hit = |hit_vec;

  always_comb begin
    rd_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_data = rd_data | rd_vec[i];
    end
  end

endmodule
